// ===== rtl/open_address_hash_table_unit_defines.svh =====
// Assertion macros used by the hash table unit.
`ifndef OPEN_ADDRESS_HASH_TABLE_UNIT_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define OAHT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash table assertion failed");

// Next-cycle implication.
`define OAHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash table assertion failed");

`endif

// ===== rtl/oaht_pkg.sv =====
`default_nettype none

package oaht_pkg;

   // Table geometry: power-of-two size, so the home slot is the low key bits
   localparam int TABLE_SIZE  = 1024;
   localparam int IDX_W       = $clog2(TABLE_SIZE);
   localparam int KEY_W       = 31;
   localparam int VAL_W       = 20;
   localparam int PROBE_W     = 11;
   localparam int STATUS_W    = 2;

   localparam logic [PROBE_W-1:0] PROBE_RESET = 11'd1024;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic             command;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    value_out;
      logic [IDX_W-1:0]    slot;
   } rsp_type;

   // One table entry as stored in memory
   typedef struct packed {
      logic             occupied;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   // Memory access request from the sequencer
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== rtl/open_address_hash_table_unit.sv =====
// Open-addressed hash table with triangular probing over 1024 slots. An item
// is a command (insert or lookup) with its key and value, taken when start is
// high and busy is low. The block probes one slot per cycle through a single
// read port on the table memory, at most max_probes slots for an item (a
// zero limit counting as one). Each result appears on rsp_data for exactly
// one cycle with rsp_valid high, in the cycle after the last probe; the
// receiver cannot stall it and must take it then. After reset the block
// runs a clearing pass over the table, one slot per cycle, with busy high;
// csr writes are taken at any time but must only be issued while no item
// is in flight.
`default_nettype none

`include "open_address_hash_table_unit_defines.svh"

module open_address_hash_table_unit
   import oaht_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire req_type            req_data,
   // result channel
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire logic [PROBE_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [PROBE_W-1:0] probe_cnt_ff, probe_cnt_in;
   logic               cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic [PROBE_W-1:0] max_probes_ff, max_probes_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   mem_req_type        mem_req;
   entry_type          rd_entry;
   logic [PROBE_W-1:0] limit;
   logic               probe_last;
   logic [IDX_W-1:0]   idx_next;

   oaht_store u_store (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_entry (rd_entry)
   );

   // Probe limit and next probe address
   assign limit      = (max_probes_ff == '0) ? PROBE_W'(1) : max_probes_ff;
   assign probe_last = (probe_cnt_ff + PROBE_W'(1)) == limit;
   assign idx_next   = idx_ff + step_ff;

   assign max_probes_in = csr_wr_en ? csr_wr_data : max_probes_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      probe_cnt_in = probe_cnt_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr_ff;
            clr_addr_in     = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = req_data.key[IDX_W-1:0];
               idx_in          = req_data.key[IDX_W-1:0];
               step_in         = IDX_W'(1);
               probe_cnt_in    = '0;
               cmd_in          = req_data.command;
               key_in          = req_data.key;
               val_in          = req_data.value;
               state_in        = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!rd_entry.occupied) begin
               // empty slot: insert lands here, lookup ends here
               rsp_valid_in          = 1'b1;
               rsp_data_in.value_out = '0;
               state_in              = ST_IDLE;
               if (cmd_ff == CMD_INSERT) begin
                  mem_req.wr_en            = 1'b1;
                  mem_req.wr_addr          = idx_ff;
                  mem_req.wr_data.occupied = 1'b1;
                  mem_req.wr_data.key      = key_ff;
                  mem_req.wr_data.value    = val_ff;
                  rsp_data_in.status       = STATUS_OK;
                  rsp_data_in.slot         = idx_ff;
               end else begin
                  rsp_data_in.status = STATUS_NOT_FOUND;
                  rsp_data_in.slot   = '0;
               end
            end else if (cmd_ff == CMD_LOOKUP && rd_entry.key == key_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = STATUS_OK;
               rsp_data_in.value_out = rd_entry.value;
               rsp_data_in.slot      = idx_ff;
               state_in              = ST_IDLE;
            end else if (probe_last) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = (cmd_ff == CMD_INSERT) ? STATUS_FULL
                                                              : STATUS_NOT_FOUND;
               rsp_data_in.value_out = '0;
               rsp_data_in.slot      = '0;
               state_in              = ST_IDLE;
            end else begin
               // move on along the triangular sequence
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_next;
               idx_in          = idx_next;
               step_in         = step_ff + IDX_W'(1);
               probe_cnt_in    = probe_cnt_ff + PROBE_W'(1);
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         max_probes_ff <= PROBE_RESET;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_probes_ff <= max_probes_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      probe_cnt_ff <= probe_cnt_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `OAHT_ASSERT_NEXT(a_accept_probes, clock, reset, start && !busy, state_ff == ST_CHECK)
   `OAHT_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   `OAHT_ASSERT_IMP(a_fail_zero_fields, clock, reset,
      rsp_valid_ff && rsp_data_ff.status != STATUS_OK,
      rsp_data_ff.slot == '0 && rsp_data_ff.value_out == '0)
   `OAHT_ASSERT_IMP(a_probe_count_steps, clock, reset,
      state_ff == ST_CHECK && $past(state_ff) == ST_CHECK,
      probe_cnt_ff == PROBE_W'($past(probe_cnt_ff) + 1'b1))

endmodule

`default_nettype wire

// ===== rtl/oaht_store.sv =====
`default_nettype none

module oaht_store
   import oaht_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output entry_type       rd_entry
);

   entry_type store_ff [TABLE_SIZE];
   entry_type rd_data_ff;

   // Single write port, single registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store_ff[mem_req.rd_addr];
      end
   end

   assign rd_entry = rd_data_ff;

endmodule

`default_nettype wire

// ===== test/open_address_hash_table_unit_tb.sv =====
module open_address_hash_table_unit_tb;
   import oaht_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 6_000_000;
   localparam int unsigned HOME_COUNT  = 24;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 94;

   // Mirror of the table contents; computes each command's outcome on accept
   class hash_table_scoreboard;
      bit                 filled[TABLE_SIZE];
      logic [KEY_W-1:0]   keys[TABLE_SIZE];
      logic [VAL_W-1:0]   vals[TABLE_SIZE];
      logic [PROBE_W-1:0] probe_limit;
      rsp_type            awaited[$];
      int unsigned        errors;
      int unsigned        inserts;
      int unsigned        lookups;
      int unsigned        checked;
      int unsigned        by_status[4];

      function new();
         probe_limit = PROBE_RESET;
      endfunction

      // Walk the triangular probe sequence exactly as the table would
      function void note_request(req_type r);
         logic [IDX_W-1:0] idx;
         int unsigned      stride;
         int unsigned      limit;
         int unsigned      p;
         rsp_type          exp;
         limit  = (probe_limit == 0) ? 1 : probe_limit;
         idx    = IDX_W'(r.key % TABLE_SIZE);
         stride = 1;
         exp.status    = (r.command == CMD_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
         exp.value_out = '0;
         exp.slot      = '0;
         for (p = 0; p < limit; p++) begin
            if (!filled[idx]) begin
               // empty slot: insert lands here, lookup gives up
               if (r.command == CMD_INSERT) begin
                  filled[idx]    = 1'b1;
                  keys[idx]      = r.key;
                  vals[idx]      = r.value;
                  exp.status     = STATUS_OK;
                  exp.slot       = idx;
               end
               break;
            end
            if (r.command == CMD_LOOKUP && keys[idx] == r.key) begin
               exp.status    = STATUS_OK;
               exp.value_out = vals[idx];
               exp.slot      = idx;
               break;
            end
            idx    = IDX_W'(idx + stride);
            stride = stride + 1;
         end
         if (r.command == CMD_INSERT) inserts++;
         else lookups++;
         by_status[exp.status]++;
         awaited.push_back(exp);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (awaited.size() == 0) begin
            $display("%0t: result with nothing pending, expected none got %h", $time, got);
            errors++;
            return;
         end
         exp = awaited.pop_front();
         checked++;
         if (got.status !== exp.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, exp.status, got.status);
            errors++;
         end
         if (got.value_out !== exp.value_out) begin
            $display("%0t: value_out mismatch, expected %h got %h",
                     $time, exp.value_out, got.value_out);
            errors++;
         end
         if (got.slot !== exp.slot) begin
            $display("%0t: slot mismatch, expected %0d got %0d",
                     $time, exp.slot, got.slot);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [PROBE_W-1:0]   csr_wr_data;

   hash_table_scoreboard sb = new();
   logic [IDX_W-1:0]     home_pool[HOME_COUNT];
   logic [KEY_W-1:0]     known_keys[$];
   int unsigned          cycles;
   int unsigned          settings;

   open_address_hash_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Results cannot be held off: every strobe is a transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, sb.awaited.size());
         $display("[open_address_hash_table_unit] ERROR");
         $finish;
      end
   end

   // Present one command, wait for its transfer, then idle for the given gap.
   // start stays high when the next command follows back to back.
   task automatic issue(input req_type r, input int unsigned gap, input bit last);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      if (last || gap != 0) start <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   // Only reprogram once the table has answered everything in flight
   task automatic set_probe_limit(input logic [PROBE_W-1:0] limit);
      while (sb.awaited.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      sb.probe_limit  = limit;
      settings++;
   endtask

   // Mostly keys that share a few home slots, so probe chains grow long
   function automatic req_type make_cmd();
      req_type     r;
      int unsigned pick;
      r.value   = VAL_W'($urandom);
      r.command = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
      pick      = $urandom_range(0, 99);
      r.key     = KEY_W'($urandom);
      if (known_keys.size() != 0 &&
          ((r.command == CMD_LOOKUP && pick < 60) || (r.command == CMD_INSERT && pick < 8)))
         r.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else if (pick < 85)
         r.key[IDX_W-1:0] = home_pool[$urandom_range(0, HOME_COUNT - 1)];
      if (r.command == CMD_INSERT) known_keys.push_back(r.key);
      return r;
   endfunction

   initial begin
      int unsigned ph;
      int unsigned i;
      int unsigned gap;
      bit          gappy;
      int unsigned limit_plan[PHASES];

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      cycles      = 0;
      settings    = 0;
      for (i = 0; i < HOME_COUNT; i++) home_pool[i] = IDX_W'($urandom_range(0, TABLE_SIZE - 1));
      limit_plan = '{0, 1, 2047, 3, 0, 1024, 2, 0};
      limit_plan[4] = $urandom_range(4, 64);
      limit_plan[7] = $urandom_range(1, 2047);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset limit, empty table, extremes, duplicates, wrap
      issue('{CMD_LOOKUP, 31'd0, 20'hFFFFF}, 0, 0);
      issue('{CMD_INSERT, 31'd0, 20'd0}, 0, 0);
      issue('{CMD_INSERT, 31'h7FFFFFFF, 20'hFFFFF}, 2, 0);
      issue('{CMD_LOOKUP, 31'h7FFFFFFF, 20'd0}, 0, 0);
      issue('{CMD_INSERT, 31'd0, 20'h12345}, 0, 0);
      issue('{CMD_LOOKUP, 31'd0, 20'd0}, 1, 0);
      issue('{CMD_INSERT, 31'd1024, 20'd7}, 0, 0);
      issue('{CMD_LOOKUP, 31'd1024, 20'd0}, 0, 0);
      issue('{CMD_LOOKUP, 31'd2048, 20'd0}, 5, 0);
      issue('{CMD_INSERT, 31'd1023, 20'hABCDE}, 0, 0);
      issue('{CMD_LOOKUP, 31'd1023, 20'd0}, 3, 1);

      // Zero limit acts as a single probe: full insert, early miss, home hit
      set_probe_limit(11'd0);
      issue('{CMD_INSERT, 31'd0, 20'd5}, 0, 0);
      issue('{CMD_LOOKUP, 31'd1024, 20'd0}, 0, 0);
      issue('{CMD_LOOKUP, 31'd0, 20'd0}, 0, 1);

      // Limit beyond table size
      set_probe_limit(11'd2047);
      issue('{CMD_INSERT, 31'h7FFFFFFF, 20'd1}, 0, 0);
      issue('{CMD_LOOKUP, 31'h7FFFFBFF, 20'd0}, 0, 1);

      // Random phases, each under its own probe limit
      for (ph = 0; ph < PHASES; ph++) begin
         set_probe_limit(PROBE_W'(limit_plan[ph]));
         gappy = (ph % 3 != 1);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            gap = gappy ? $urandom_range(0, 15) : 0;
            issue(make_cmd(), gap, i == PHASE_ITEMS - 1);
         end
      end

      // Drain, then watch for stray strobes
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d inserts and %0d lookups under %0d probe limits; %0d results checked.",
               sb.inserts, sb.lookups, settings, sb.checked);
      $display("Outcomes: %0d ok, %0d not found, %0d full; %0d mismatches.",
               sb.by_status[STATUS_OK], sb.by_status[STATUS_NOT_FOUND],
               sb.by_status[STATUS_FULL], sb.errors);
      if (sb.errors == 0) begin
         $display("[open_address_hash_table_unit] OK");
      end else begin
         $display("[open_address_hash_table_unit] ERROR");
      end
      $finish;
   end

endmodule
